### rtl/core/sensor_frame_length_sum_parser_core_assert.svh
// Assertion macros shared by the sensor frame parser RTL.
// Depends on nothing; compiled out when SYNTH is defined.
`ifndef SENSOR_FRAME_LENGTH_SUM_PARSER_CORE_ASSERT_SVH
`define SENSOR_FRAME_LENGTH_SUM_PARSER_CORE_ASSERT_SVH

`ifndef SYNTH

// Condition holds at every clock edge outside reset
`define SFLP_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("sflp assertion failed");

// Antecedent in one cycle implies consequent in the next
`define SFLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sflp assertion failed");

`else

`define SFLP_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define SFLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### rtl/core/sflp_pkg.sv
// Shared types and constants of the sensor frame parser.
// Used by the config registers, the deframer, the result register and the top.
package sflp_pkg;

	// largest payload length accepted in a frame
	localparam int MaxPayload = 25;
	localparam int LenW       = $clog2(MaxPayload + 1);

	// config register file
	localparam int PaddrW       = 3;
	localparam int PdataW       = 32;
	localparam logic [7:0] HeaderByteRst     = 8'h5A;
	localparam logic [7:0] ValueFrameTypeRst = 8'h82;

	// register index taken from paddr[2]
	typedef enum logic {
		REG_HEADER_BYTE      = 1'b0,
		REG_VALUE_FRAME_TYPE = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		STATUS_GOOD    = 2'd0,
		STATUS_SUM_ERR = 2'd1,
		STATUS_LEN_ERR = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] header_byte;
		logic [7:0] value_frame_type;
	} cfg_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  frame_type;
		logic [31:0] value;
		logic        value_valid;
	} result_t;

endpackage

### rtl/core/sflp_cfg_regs.sv
// APB-style register file holding the sync byte and the value frame type.
// Depends on sflp_pkg.
module sflp_cfg_regs import sflp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [PaddrW-1:0] paddr,
	input  logic [PdataW-1:0] pwdata,
	output logic [PdataW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     wr_en;

	assign reg_idx = reg_idx_t'(paddr[2]);
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_byte      <= HeaderByteRst;
			cfg_q.value_frame_type <= ValueFrameTypeRst;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_HEADER_BYTE:      cfg_q.header_byte      <= pwdata[7:0];
				REG_VALUE_FRAME_TYPE: cfg_q.value_frame_type <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read mux, low address bits ignored
	always_comb begin
		unique case (reg_idx)
			REG_HEADER_BYTE:      prdata = PdataW'(cfg_q.header_byte);
			REG_VALUE_FRAME_TYPE: prdata = PdataW'(cfg_q.value_frame_type);
			default:              prdata = '0;
		endcase
	end

endmodule

### rtl/core/sflp_deframer.sv
// Frame state machine: sync search, type, length, payload and checksum check.
// Depends on sflp_pkg; one byte is consumed per step.
module sflp_deframer import sflp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic [7:0] rx_byte,
	input  logic       step,
	output logic       res_hit,
	output result_t    res
);

	typedef enum logic [4:0] {
		PH_SYNC0 = 5'b00001,
		PH_SYNC1 = 5'b00010,
		PH_TYPE  = 5'b00100,
		PH_LEN   = 5'b01000,
		PH_BODY  = 5'b10000
	} phase_t;

	localparam logic [7:0]      MaxPayloadB = 8'(MaxPayload);
	localparam logic [LenW-1:0] ValueBytes  = LenW'(4);

	phase_t          phase_q, phase_d;
	logic [LenW-1:0] len_q, len_d;
	logic [LenW-1:0] idx_q, idx_d;
	logic [7:0]      sum_q, sum_d;
	logic [7:0]      type_q, type_d;
	logic [31:0]     shift_q, shift_d;

	logic       hdr_ok;
	logic       len_bad;
	logic       in_payload;
	logic       long_enough;
	logic       sum_ok;
	logic [7:0] sum_add;

	assign hdr_ok      = (rx_byte == cfg.header_byte);
	assign len_bad     = (rx_byte > MaxPayloadB);
	assign in_payload  = (idx_q < len_q);
	assign long_enough = (len_q >= ValueBytes);
	assign sum_ok      = (sum_q == rx_byte);
	assign sum_add     = sum_q + rx_byte;

	// a result comes from an oversized length or from the checksum byte
	assign res_hit = ((phase_q == PH_LEN) && len_bad) ||
		((phase_q == PH_BODY) && !in_payload);

	// result fields
	always_comb begin
		if (phase_q == PH_LEN) begin
			res.status      = STATUS_LEN_ERR;
			res.frame_type  = type_q;
			res.value       = '0;
			res.value_valid = 1'b0;
		end else begin
			res.status      = sum_ok ? STATUS_GOOD : STATUS_SUM_ERR;
			res.frame_type  = type_q;
			res.value       = long_enough ? shift_q : '0;
			res.value_valid = sum_ok && long_enough &&
				(type_q == cfg.value_frame_type);
		end
	end

	// next state; default is a restart of the sync search
	always_comb begin
		phase_d = PH_SYNC0;
		len_d   = '0;
		idx_d   = '0;
		sum_d   = '0;
		type_d  = '0;
		shift_d = '0;
		unique case (phase_q)
			PH_SYNC0: begin
				if (hdr_ok) begin
					phase_d = PH_SYNC1;
					sum_d   = rx_byte;
				end
			end
			PH_SYNC1: begin
				if (hdr_ok) begin
					phase_d = PH_TYPE;
					sum_d   = sum_add;
				end
			end
			PH_TYPE: begin
				phase_d = PH_LEN;
				sum_d   = sum_add;
				type_d  = rx_byte;
			end
			PH_LEN: begin
				if (!len_bad) begin
					phase_d = PH_BODY;
					sum_d   = sum_add;
					type_d  = type_q;
					len_d   = rx_byte[LenW-1:0];
				end
			end
			PH_BODY: begin
				if (in_payload) begin
					phase_d = PH_BODY;
					sum_d   = sum_add;
					type_d  = type_q;
					len_d   = len_q;
					idx_d   = idx_q + 1'b1;
					shift_d = (idx_q < ValueBytes) ? {shift_q[23:0], rx_byte} : shift_q;
				end
			end
			default: ;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC0;
			len_q   <= '0;
			idx_q   <= '0;
			sum_q   <= '0;
			type_q  <= '0;
			shift_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			len_q   <= len_d;
			idx_q   <= idx_d;
			sum_q   <= sum_d;
			type_q  <= type_d;
			shift_q <= shift_d;
		end
	end

endmodule

### rtl/core/sflp_result_reg.sv
// Output register of the result channel with valid/stall handshake.
// Depends on sflp_pkg for the result struct.
module sflp_result_reg import sflp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res_in,
	output logic    free,
	output logic    res_valid,
	input  logic    res_stall,
	output result_t res_out
);

	logic    valid_q;
	result_t res_q;

	// room when empty or when the held request leaves this cycle
	assign free      = !valid_q || !res_stall;
	assign res_valid = valid_q;
	assign res_out   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!res_stall) begin
			valid_q <= 1'b0;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

### rtl/core/sensor_frame_length_sum_parser_core.sv
// Sensor frame parser, top level: input register, deframer, result register.
// Depends on sflp_pkg, sflp_cfg_regs, sflp_deframer, sflp_result_reg and the assert header.
//
// Usage:
//  - rx channel: one received byte per request (rx_valid, rx_stall, rx_byte).
//  - res channel: one request per finished frame or per oversized length
//    (res_valid, res_stall, status, frame_type, value, value_valid).
//  - APB port: header_byte at address 0, value_frame_type at address 4;
//    write only while no frame is in flight.
//  - Throughput: one byte per cycle while rx_stall is low. Each byte is
//    registered, then the deframer updates its state when the byte advances.
//  - Result path: a checksum (or length) byte is held in the input register,
//    then its result is loaded into the output register and shown on res_valid.
//  - Stall: a held result waits in the output register; bytes that give no
//    result keep flowing, and the input stalls only when a byte that gives a
//    result finds the output register full and stalled.
//  - Reset: the sync search restarts, both channels go empty and the
//    registers return to 0x5A and 0x82.
`include "sensor_frame_length_sum_parser_core_assert.svh"

module sensor_frame_length_sum_parser_core import sflp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [PaddrW-1:0] paddr,
	input  logic [PdataW-1:0] pwdata,
	output logic [PdataW-1:0] prdata,
	output logic              pready,
	// received bytes
	input  logic              rx_valid,
	output logic              rx_stall,
	input  logic [7:0]        rx_byte,
	// results
	output logic              res_valid,
	input  logic              res_stall,
	output logic [1:0]        status,
	output logic [7:0]        frame_type,
	output logic [31:0]       value,
	output logic              value_valid
);

	cfg_t       cfg;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       res_hit;
	logic       out_free;
	logic       advance;
	logic       load;
	logic       rx_take;
	result_t    res_new;
	result_t    res_out;

	sflp_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// handshake between input register and result register
	assign advance  = valid_s1 && (!res_hit || out_free);
	assign load     = advance && res_hit;
	assign rx_stall = valid_s1 && !advance;
	assign rx_take  = rx_valid && !rx_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_take) begin
			byte_s1 <= rx_byte;
		end
	end

	sflp_deframer u_deframer (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.rx_byte(byte_s1),
		.step   (advance),
		.res_hit(res_hit),
		.res    (res_new)
	);

	sflp_result_reg u_result (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.res_in   (res_new),
		.free     (out_free),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_out  (res_out)
	);

	assign status      = res_out.status;
	assign frame_type  = res_out.frame_type;
	assign value       = res_out.value;
	assign value_valid = res_out.value_valid;

	// input stalls only behind a result that cannot enter the output register
	`SFLP_ASSERT_ALWAYS(a_stall_cause, clk, arst_n, !rx_stall || (res_hit && !out_free))
	// a new result never overwrites one still held
	`SFLP_ASSERT_ALWAYS(a_no_overwrite, clk, arst_n, !load || !res_valid || !res_stall)
	// an accepted byte is held in the input register next cycle
	`SFLP_ASSERT_NEXT(a_take_s1, clk, arst_n, rx_take, valid_s1)
	// a loaded result appears on the output next cycle
	`SFLP_ASSERT_NEXT(a_load_out, clk, arst_n, load, res_valid)

endmodule

### dv/sensor_frame_length_sum_parser_core_test.sv
// Self-checking bench for sensor_frame_length_sum_parser_core: directed frames, then
// random frame traffic under several register settings, with random sender pauses and result stalls.
// Depends on sflp_pkg and the core RTL only.
`timescale 1ns / 100ps

module sensor_frame_length_sum_parser_core_test;
	import sflp_pkg::*;

	// one row of the directed table; want is used only where typed is set
	typedef struct {
		logic [7:0] rx;
		bit         typed;
		result_t    want;
	} stim_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel, penable, pwrite;
	logic [PaddrW-1:0] paddr;
	logic [PdataW-1:0] pwdata;
	logic [PdataW-1:0] prdata;
	logic              pready;
	logic              rx_valid;
	logic              rx_stall;
	logic [7:0]        rx_byte;
	logic              res_valid;
	logic              res_stall = 1'b0;
	logic [1:0]        status;
	logic [7:0]        frame_type;
	logic [31:0]       value;
	logic              value_valid;

	// deframer state as predicted, plus the register copies
	logic [7:0]  hdr_cfg   = HeaderByteRst;
	logic [7:0]  vtype_cfg = ValueFrameTypeRst;
	logic [7:0]  fr_pos    = '0;
	logic [7:0]  fr_len    = '0;
	logic [7:0]  fr_sum    = '0;
	logic [7:0]  fr_type   = '0;
	logic [31:0] fr_value  = '0;

	result_t   frames_due[$];
	int        mismatch_count = 0;
	bit        no_idle = 1'b0;
	logic      long_hold_req = 1'b0;
	bit        long_hold_done = 1'b0;
	int        stall_left = 0;
	stim_row_t directed_rows [21];

	sensor_frame_length_sum_parser_core dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.rx_valid(rx_valid), .rx_stall(rx_stall), .rx_byte(rx_byte),
		.res_valid(res_valid), .res_stall(res_stall),
		.status(status), .frame_type(frame_type), .value(value), .value_valid(value_valid)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	function automatic void restart_hunt();
		fr_pos   = '0;
		fr_len   = '0;
		fr_sum   = '0;
		fr_type  = '0;
		fr_value = '0;
	endfunction

	// advance the predicted deframer by one byte; returns 1 when a frame result is due
	function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
		r = '0;
		// sync bytes
		if (fr_pos <= 8'd1) begin
			if (b != hdr_cfg) begin
				restart_hunt();
				return 1'b0;
			end
			fr_sum = fr_sum + b;
			fr_pos = fr_pos + 8'd1;
			return 1'b0;
		end
		if (fr_pos == 8'd2) begin
			fr_type = b;
			fr_sum  = fr_sum + b;
			fr_pos  = 8'd3;
			return 1'b0;
		end
		// length byte; oversized gives an error result at once
		if (fr_pos == 8'd3) begin
			if (b > MaxPayload) begin
				r.status     = STATUS_LEN_ERR;
				r.frame_type = fr_type;
				restart_hunt();
				return 1'b1;
			end
			fr_len = b;
			fr_sum = fr_sum + b;
			fr_pos = 8'd4;
			return 1'b0;
		end
		// payload; first four bytes build the value
		if (fr_pos - 8'd4 < fr_len) begin
			if (fr_pos < 8'd8)
				fr_value = {fr_value[23:0], b};
			fr_sum = fr_sum + b;
			fr_pos = fr_pos + 8'd1;
			return 1'b0;
		end
		// checksum byte
		if (fr_sum == b)
			r.status = STATUS_GOOD;
		else
			r.status = STATUS_SUM_ERR;
		r.frame_type  = fr_type;
		r.value       = (fr_len >= 8'd4) ? fr_value : '0;
		r.value_valid = (fr_sum == b) && (fr_len >= 8'd4) && (fr_type == vtype_cfg);
		restart_hunt();
		return 1'b1;
	endfunction

	// offer one byte, wait for the request to be taken, then predict
	task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
			input result_t want = '0);
		result_t r;
		if (!no_idle && $urandom_range(0, 7) == 0) begin
			rx_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (rx_stall);
		if (deframe_byte(b, r))
			frames_due.push_back(typed ? want : r);
	endtask

	// write a register, read it back, update the predictor copy
	task automatic set_register(input reg_idx_t idx, input logic [7:0] d);
		logic [PdataW-1:0] rd;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PaddrW'({idx, 2'b00});
		pwdata  <= PdataW'(d);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		// read-back: setup, then access
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		rd = prdata;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (rd[7:0] !== d)
			report_mismatch($sformatf("register %s reads %0h, wrote %0h", idx.name(), rd, d));
		if (idx == REG_HEADER_BYTE)
			hdr_cfg = d;
		else
			vtype_cfg = d;
	endtask

	// mostly well-formed frames with random content; some noise, bad sync,
	// oversized lengths, cut-off frames and some bad checksums
	task automatic random_frames(input int budget);
		int         sent, kind, len, cut;
		logic [7:0] ftype, ck, b;
		sent = 0;
		while (sent < budget) begin
			kind = $urandom_range(0, 99);
			if (kind < 8) begin
				// line noise, never a sync byte
				b = 8'($urandom);
				if (b == hdr_cfg)
					b = ~b;
				send_byte(b);
				sent++;
			end else if (kind < 14) begin
				// first sync byte, then a wrong second one
				b = 8'($urandom);
				if (b == hdr_cfg)
					b = ~b;
				send_byte(hdr_cfg);
				send_byte(b);
				sent += 2;
			end else begin
				ftype = ($urandom_range(0, 1) == 0) ? vtype_cfg : 8'($urandom);
				if (kind < 20)
					len = $urandom_range(MaxPayload + 1, 255);
				else if ($urandom_range(0, 4) == 0)
					len = $urandom_range(0, MaxPayload);
				else
					len = $urandom_range(0, 6);
				cut = (kind < 23 && len >= 2) ? $urandom_range(0, len - 1) : len;
				ck = hdr_cfg + hdr_cfg + ftype + 8'(len);
				send_byte(hdr_cfg);
				send_byte(hdr_cfg);
				send_byte(ftype);
				send_byte(8'(len));
				sent += 4;
				if (len <= MaxPayload) begin
					for (int i = 0; i < cut; i++) begin
						b = 8'($urandom);
						ck = ck + b;
						send_byte(b);
					end
					sent += cut;
					if (cut == len) begin
						if ($urandom_range(0, 6) == 0)
							ck = ck + 8'($urandom_range(1, 255));
						send_byte(ck);
						sent++;
					end
				end
			end
		end
		// finish any frame left open so registers change between frames
		while (fr_pos != 8'd0)
			send_byte(8'($urandom));
	endtask

	// result side: check taken requests, then pick the next stall
	always @(posedge clk) begin
		result_t e;
		if (!arst_n) begin
			res_stall  <= 1'b0;
			stall_left <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (frames_due.size() == 0) begin
					report_mismatch("frame result with none pending");
				end else begin
					e = frames_due.pop_front();
					if (status !== e.status)
						report_mismatch($sformatf("status %0d, want %0d", status, e.status));
					if (frame_type !== e.frame_type)
						report_mismatch($sformatf("frame_type %0h, want %0h",
							frame_type, e.frame_type));
					if (value !== e.value)
						report_mismatch($sformatf("value %0h, want %0h", value, e.value));
					if (value_valid !== e.value_valid)
						report_mismatch($sformatf("value_valid %0b, want %0b",
							value_valid, e.value_valid));
				end
			end
			// one long hold while the sender keeps going, else short bursts
			if (long_hold_req && !long_hold_done) begin
				long_hold_done <= 1'b1;
				stall_left     <= 89;
				res_stall      <= 1'b1;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				res_stall  <= 1'b1;
			end else if (!no_idle && $urandom_range(0, 9) == 0) begin
				stall_left <= $urandom_range(0, 12);
				res_stall  <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	// run limit
	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		rx_valid = 1'b0;
		rx_byte  = '0;

		// after reset: oversized length, bad sync, empty frame with bad sum, value frame
		directed_rows = '{
			'{HeaderByteRst, 1'b0, '0},
			'{HeaderByteRst, 1'b0, '0},
			'{ValueFrameTypeRst, 1'b0, '0},
			'{8'h1A, 1'b1, '{STATUS_LEN_ERR, ValueFrameTypeRst, 32'h0, 1'b0}},
			'{8'h00, 1'b0, '0},
			'{HeaderByteRst, 1'b0, '0},
			'{8'h00, 1'b0, '0},
			'{HeaderByteRst, 1'b0, '0},
			'{HeaderByteRst, 1'b0, '0},
			'{ValueFrameTypeRst, 1'b0, '0},
			'{8'h00, 1'b0, '0},
			'{8'h00, 1'b1, '{STATUS_SUM_ERR, ValueFrameTypeRst, 32'h0, 1'b0}},
			'{HeaderByteRst, 1'b0, '0},
			'{HeaderByteRst, 1'b0, '0},
			'{ValueFrameTypeRst, 1'b0, '0},
			'{8'h04, 1'b0, '0},
			'{8'hFF, 1'b0, '0},
			'{8'hFF, 1'b0, '0},
			'{8'hFF, 1'b0, '0},
			'{8'hFF, 1'b0, '0},
			'{8'h36, 1'b1, '{STATUS_GOOD, ValueFrameTypeRst, 32'hFFFF_FFFF, 1'b1}}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(directed_rows); i++)
			send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);

		for (int ph = 0; ph < 5; ph++) begin
			// sender pauses until every frame result is back, then the pipe drains
			rx_valid <= 1'b0;
			while (frames_due.size() != 0) @(posedge clk);
			repeat (4) @(posedge clk);
			case (ph)
				0: begin
					set_register(REG_HEADER_BYTE, 8'h00);
					set_register(REG_VALUE_FRAME_TYPE, 8'h00);
				end
				1: begin
					set_register(REG_HEADER_BYTE, 8'hFF);
					set_register(REG_VALUE_FRAME_TYPE, 8'hFF);
					long_hold_req <= 1'b1;
				end
				4: begin
					set_register(REG_HEADER_BYTE, HeaderByteRst);
					set_register(REG_VALUE_FRAME_TYPE, ValueFrameTypeRst);
					no_idle = 1'b1;
				end
				default: begin
					set_register(REG_HEADER_BYTE, 8'($urandom));
					set_register(REG_VALUE_FRAME_TYPE, 8'($urandom));
				end
			endcase
			random_frames(250);
		end

		rx_valid <= 1'b0;
		while (frames_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

### files.f
+incdir+rtl/core
rtl/core/sflp_pkg.sv
rtl/core/sflp_cfg_regs.sv
rtl/core/sflp_deframer.sv
rtl/core/sflp_result_reg.sv
rtl/core/sensor_frame_length_sum_parser_core.sv
dv/sensor_frame_length_sum_parser_core_test.sv
